>>> src/psmu_pkg.sv
// ----------------------------------------------------------------------------
// psmu_pkg - shared types, constants and microcode for the scalar multiplier
// field sizes, command codes, sequencer states, microcode rom and the
// folding modular adder used by the shared arithmetic unit
// ----------------------------------------------------------------------------
package psmu_pkg;

    localparam int LIMB_COUNT = 4;
    localparam int LIMB_BITS  = 64;
    localparam int FIELD_BITS = LIMB_COUNT * LIMB_BITS;
    localparam int CNT_W      = $clog2(FIELD_BITS);
    localparam int SLOT_W     = 5;
    localparam int SLOT_COUNT = 1 << SLOT_W;
    localparam int PC_W       = 7;
    localparam int CFG_AW     = 6;

    // input commands
    localparam logic [2:0] CMD_LOAD_X = 3'd0;
    localparam logic [2:0] CMD_LOAD_Y = 3'd1;
    localparam logic [2:0] CMD_LOAD_Z = 3'd2;
    localparam logic [2:0] CMD_LOAD_K = 3'd3;
    localparam logic [2:0] CMD_START  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_A0 = 3'd0;
    localparam logic [2:0] REG_COEF_A1 = 3'd1;
    localparam logic [2:0] REG_COEF_A2 = 3'd2;
    localparam logic [2:0] REG_COEF_A3 = 3'd3;
    localparam logic [2:0] REG_PRIME0  = 3'd4;
    localparam logic [2:0] REG_PRIME1  = 3'd5;
    localparam logic [2:0] REG_PRIME2  = 3'd6;
    localparam logic [2:0] REG_PRIME3  = 3'd7;

    localparam logic [FIELD_BITS-1:0] COEF_A_RESET =
        {64'hFFFFFFFF00000001, 64'h0000000000000000,
         64'h00000000FFFFFFFF, 64'hFFFFFFFFFFFFFFFC};
    localparam logic [FIELD_BITS-1:0] PRIME_RESET =
        {64'hFFFFFFFF00000001, 64'h0000000000000000,
         64'h00000000FFFFFFFF, 64'hFFFFFFFFFFFFFFFF};

    // result coordinate codes
    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Z = 2'd2;

    typedef enum logic [3:0] {
        OP_MUL, OP_MULA, OP_RED, OP_ADD, OP_SUB, OP_MOV, OP_SETK, OP_JZ,
        OP_JNZ, OP_JNE, OP_JMP, OP_JBIT, OP_CALL, OP_RET, OP_NEXT
    } uop_t;

    typedef struct packed {
        uop_t              op;
        logic [SLOT_W-1:0] dst;
        logic [SLOT_W-1:0] srca;
        logic [SLOT_W-1:0] srcb;
        logic [PC_W-1:0]   tgt;
    } uinstr_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIND, ST_RDA, ST_RDB, ST_CAP, ST_EXEC, ST_RED, ST_MDBL,
        ST_MADD, ST_OZRD, ST_OZCAP, ST_ORD, ST_OCAP, ST_OSEND
    } st_t;

    // working store slots
    localparam logic [SLOT_W-1:0] R0X = 5'd0;
    localparam logic [SLOT_W-1:0] R0Y = 5'd1;
    localparam logic [SLOT_W-1:0] R0Z = 5'd2;
    localparam logic [SLOT_W-1:0] R1X = 5'd3;
    localparam logic [SLOT_W-1:0] R1Y = 5'd4;
    localparam logic [SLOT_W-1:0] R1Z = 5'd5;
    localparam logic [SLOT_W-1:0] PX  = 5'd6;
    localparam logic [SLOT_W-1:0] PY  = 5'd7;
    localparam logic [SLOT_W-1:0] PZ  = 5'd8;
    localparam logic [SLOT_W-1:0] QX  = 5'd9;
    localparam logic [SLOT_W-1:0] QY  = 5'd10;
    localparam logic [SLOT_W-1:0] QZ  = 5'd11;
    localparam logic [SLOT_W-1:0] SX  = 5'd12;
    localparam logic [SLOT_W-1:0] SY  = 5'd13;
    localparam logic [SLOT_W-1:0] SZ  = 5'd14;
    localparam logic [SLOT_W-1:0] T0  = 5'd15;
    localparam logic [SLOT_W-1:0] T1  = 5'd16;
    localparam logic [SLOT_W-1:0] T2  = 5'd17;
    localparam logic [SLOT_W-1:0] T3  = 5'd18;
    localparam logic [SLOT_W-1:0] T4  = 5'd19;
    localparam logic [SLOT_W-1:0] T5  = 5'd20;
    localparam logic [SLOT_W-1:0] T6  = 5'd21;
    localparam logic [SLOT_W-1:0] T7  = 5'd22;
    localparam logic [SLOT_W-1:0] T8  = 5'd23;
    localparam logic [SLOT_W-1:0] T9  = 5'd24;
    localparam logic [SLOT_W-1:0] T10 = 5'd25;
    localparam logic [SLOT_W-1:0] T11 = 5'd26;
    localparam logic [SLOT_W-1:0] T12 = 5'd27;
    localparam logic [SLOT_W-1:0] T13 = 5'd28;
    localparam logic [SLOT_W-1:0] T14 = 5'd29;
    localparam logic [SLOT_W-1:0] T15 = 5'd30;
    localparam logic [SLOT_W-1:0] T16 = 5'd31;
    localparam logic [SLOT_W-1:0] NA  = 5'd0;

    // small immediates and base coordinate selectors in the srca field
    localparam logic [SLOT_W-1:0] K0     = 5'd0;
    localparam logic [SLOT_W-1:0] K1     = 5'd1;
    localparam logic [SLOT_W-1:0] BASE_X = 5'd0;
    localparam logic [SLOT_W-1:0] BASE_Y = 5'd1;
    localparam logic [SLOT_W-1:0] BASE_Z = 5'd2;

    // routine entry points
    localparam logic [PC_W-1:0] L_START = 7'd0;
    localparam logic [PC_W-1:0] L_STEP  = 7'd10;
    localparam logic [PC_W-1:0] L_BIT1  = 7'd26;
    localparam logic [PC_W-1:0] L_NEXT  = 7'd36;
    localparam logic [PC_W-1:0] L_ADD   = 7'd38;
    localparam logic [PC_W-1:0] L_ADDQ  = 7'd43;
    localparam logic [PC_W-1:0] L_ADDG  = 7'd48;
    localparam logic [PC_W-1:0] L_ADDV  = 7'd55;
    localparam logic [PC_W-1:0] L_INFS  = 7'd73;
    localparam logic [PC_W-1:0] L_DBL   = 7'd77;
    localparam logic [PC_W-1:0] NT      = 7'd0;

    function automatic uinstr_t mk(uop_t op, logic [SLOT_W-1:0] d, logic [SLOT_W-1:0] a,
                                   logic [SLOT_W-1:0] b, logic [PC_W-1:0] t);
        uinstr_t u;
        u.op   = op;
        u.dst  = d;
        u.srca = a;
        u.srcb = b;
        u.tgt  = t;
        return u;
    endfunction

    // ladder program: set-up, one step per scalar bit, point add, point double
    function automatic uinstr_t ucode(logic [PC_W-1:0] pc);
        uinstr_t u;
        case (pc)
            7'd0:   u = mk(OP_RED,  R1X, BASE_X, NA, NT);
            7'd1:   u = mk(OP_RED,  R1Y, BASE_Y, NA, NT);
            7'd2:   u = mk(OP_RED,  R1Z, BASE_Z, NA, NT);
            7'd3:   u = mk(OP_SETK, R0X, K0, NA, NT);
            7'd4:   u = mk(OP_SETK, R0Y, K1, NA, NT);
            7'd5:   u = mk(OP_SETK, R0Z, K0, NA, NT);
            7'd6:   u = mk(OP_JNZ,  NA,  R1Z, NA, L_STEP);
            7'd7:   u = mk(OP_SETK, R1X, K0, NA, NT);
            7'd8:   u = mk(OP_SETK, R1Y, K1, NA, NT);
            7'd9:   u = mk(OP_SETK, R1Z, K0, NA, NT);
            // ladder step
            7'd10:  u = mk(OP_MOV,  PX, R0X, NA, NT);
            7'd11:  u = mk(OP_MOV,  PY, R0Y, NA, NT);
            7'd12:  u = mk(OP_MOV,  PZ, R0Z, NA, NT);
            7'd13:  u = mk(OP_MOV,  QX, R1X, NA, NT);
            7'd14:  u = mk(OP_MOV,  QY, R1Y, NA, NT);
            7'd15:  u = mk(OP_MOV,  QZ, R1Z, NA, NT);
            7'd16:  u = mk(OP_CALL, NA, NA, NA, L_ADD);
            7'd17:  u = mk(OP_JBIT, NA, NA, NA, L_BIT1);
            7'd18:  u = mk(OP_MOV,  R1X, SX, NA, NT);
            7'd19:  u = mk(OP_MOV,  R1Y, SY, NA, NT);
            7'd20:  u = mk(OP_MOV,  R1Z, SZ, NA, NT);
            7'd21:  u = mk(OP_CALL, NA, NA, NA, L_DBL);
            7'd22:  u = mk(OP_MOV,  R0X, SX, NA, NT);
            7'd23:  u = mk(OP_MOV,  R0Y, SY, NA, NT);
            7'd24:  u = mk(OP_MOV,  R0Z, SZ, NA, NT);
            7'd25:  u = mk(OP_JMP,  NA, NA, NA, L_NEXT);
            7'd26:  u = mk(OP_MOV,  R0X, SX, NA, NT);
            7'd27:  u = mk(OP_MOV,  R0Y, SY, NA, NT);
            7'd28:  u = mk(OP_MOV,  R0Z, SZ, NA, NT);
            7'd29:  u = mk(OP_MOV,  PX, R1X, NA, NT);
            7'd30:  u = mk(OP_MOV,  PY, R1Y, NA, NT);
            7'd31:  u = mk(OP_MOV,  PZ, R1Z, NA, NT);
            7'd32:  u = mk(OP_CALL, NA, NA, NA, L_DBL);
            7'd33:  u = mk(OP_MOV,  R1X, SX, NA, NT);
            7'd34:  u = mk(OP_MOV,  R1Y, SY, NA, NT);
            7'd35:  u = mk(OP_MOV,  R1Z, SZ, NA, NT);
            7'd36:  u = mk(OP_NEXT, NA, NA, NA, L_STEP);
            7'd37:  u = mk(OP_JMP,  NA, NA, NA, L_STEP);
            // point add: S = P + Q, P left intact
            7'd38:  u = mk(OP_JNZ,  NA, PZ, NA, L_ADDQ);
            7'd39:  u = mk(OP_MOV,  SX, QX, NA, NT);
            7'd40:  u = mk(OP_MOV,  SY, QY, NA, NT);
            7'd41:  u = mk(OP_MOV,  SZ, QZ, NA, NT);
            7'd42:  u = mk(OP_RET,  NA, NA, NA, NT);
            7'd43:  u = mk(OP_JNZ,  NA, QZ, NA, L_ADDG);
            7'd44:  u = mk(OP_MOV,  SX, PX, NA, NT);
            7'd45:  u = mk(OP_MOV,  SY, PY, NA, NT);
            7'd46:  u = mk(OP_MOV,  SZ, PZ, NA, NT);
            7'd47:  u = mk(OP_RET,  NA, NA, NA, NT);
            7'd48:  u = mk(OP_MUL,  T0, QY, PZ, NT);
            7'd49:  u = mk(OP_MUL,  T1, PY, QZ, NT);
            7'd50:  u = mk(OP_MUL,  T2, QX, PZ, NT);
            7'd51:  u = mk(OP_MUL,  T3, PX, QZ, NT);
            7'd52:  u = mk(OP_JNE,  NA, T2, T3, L_ADDV);
            7'd53:  u = mk(OP_JNE,  NA, T0, T1, L_INFS);
            7'd54:  u = mk(OP_JMP,  NA, NA, NA, L_DBL);
            7'd55:  u = mk(OP_SUB,  T4, T0, T1, NT);
            7'd56:  u = mk(OP_SUB,  T5, T2, T3, NT);
            7'd57:  u = mk(OP_MUL,  T6, PZ, QZ, NT);
            7'd58:  u = mk(OP_MUL,  T7, T5, T5, NT);
            7'd59:  u = mk(OP_MUL,  T8, T7, T5, NT);
            7'd60:  u = mk(OP_MUL,  T9, T7, T3, NT);
            7'd61:  u = mk(OP_MUL,  T10, T4, T4, NT);
            7'd62:  u = mk(OP_MUL,  T10, T10, T6, NT);
            7'd63:  u = mk(OP_SUB,  T10, T10, T8, NT);
            7'd64:  u = mk(OP_ADD,  T11, T9, T9, NT);
            7'd65:  u = mk(OP_SUB,  T10, T10, T11, NT);
            7'd66:  u = mk(OP_MUL,  SX, T5, T10, NT);
            7'd67:  u = mk(OP_SUB,  T11, T9, T10, NT);
            7'd68:  u = mk(OP_MUL,  T11, T4, T11, NT);
            7'd69:  u = mk(OP_MUL,  T12, T8, T1, NT);
            7'd70:  u = mk(OP_SUB,  SY, T11, T12, NT);
            7'd71:  u = mk(OP_MUL,  SZ, T8, T6, NT);
            7'd72:  u = mk(OP_RET,  NA, NA, NA, NT);
            // S = infinity
            7'd73:  u = mk(OP_SETK, SX, K0, NA, NT);
            7'd74:  u = mk(OP_SETK, SY, K1, NA, NT);
            7'd75:  u = mk(OP_SETK, SZ, K0, NA, NT);
            7'd76:  u = mk(OP_RET,  NA, NA, NA, NT);
            // point double: S = 2P
            7'd77:  u = mk(OP_JZ,   NA, PZ, NA, L_INFS);
            7'd78:  u = mk(OP_JZ,   NA, PY, NA, L_INFS);
            7'd79:  u = mk(OP_MUL,  T13, PX, PX, NT);
            7'd80:  u = mk(OP_MUL,  T14, PZ, PZ, NT);
            7'd81:  u = mk(OP_MULA, T14, NA, T14, NT);
            7'd82:  u = mk(OP_ADD,  T15, T13, T13, NT);
            7'd83:  u = mk(OP_ADD,  T15, T15, T13, NT);
            7'd84:  u = mk(OP_ADD,  T14, T14, T15, NT);
            7'd85:  u = mk(OP_MUL,  T15, PY, PZ, NT);
            7'd86:  u = mk(OP_MUL,  T16, PX, PY, NT);
            7'd87:  u = mk(OP_MUL,  T16, T16, T15, NT);
            7'd88:  u = mk(OP_ADD,  T16, T16, T16, NT);
            7'd89:  u = mk(OP_ADD,  T16, T16, T16, NT);
            7'd90:  u = mk(OP_ADD,  T13, T16, T16, NT);
            7'd91:  u = mk(OP_MUL,  T0, T14, T14, NT);
            7'd92:  u = mk(OP_SUB,  T0, T0, T13, NT);
            7'd93:  u = mk(OP_ADD,  T1, T0, T0, NT);
            7'd94:  u = mk(OP_MUL,  SX, T1, T15, NT);
            7'd95:  u = mk(OP_MUL,  T2, PY, PY, NT);
            7'd96:  u = mk(OP_MUL,  T3, T15, T15, NT);
            7'd97:  u = mk(OP_MUL,  T2, T2, T3, NT);
            7'd98:  u = mk(OP_ADD,  T2, T2, T2, NT);
            7'd99:  u = mk(OP_ADD,  T2, T2, T2, NT);
            7'd100: u = mk(OP_ADD,  T2, T2, T2, NT);
            7'd101: u = mk(OP_SUB,  T4, T16, T0, NT);
            7'd102: u = mk(OP_MUL,  T4, T14, T4, NT);
            7'd103: u = mk(OP_SUB,  SY, T4, T2, NT);
            7'd104: u = mk(OP_MUL,  T5, T3, T15, NT);
            7'd105: u = mk(OP_ADD,  T5, T5, T5, NT);
            7'd106: u = mk(OP_ADD,  T5, T5, T5, NT);
            7'd107: u = mk(OP_ADD,  SZ, T5, T5, NT);
            7'd108: u = mk(OP_RET,  NA, NA, NA, NT);
            default: u = mk(OP_RET, NA, NA, NA, NT);
        endcase
        return u;
    endfunction

    // x + y + cin, then one subtraction of p when the sum reaches it
    function automatic logic [FIELD_BITS-1:0] fold_add(logic [FIELD_BITS-1:0] x,
                                                       logic [FIELD_BITS-1:0] y,
                                                       logic cin,
                                                       logic [FIELD_BITS-1:0] p);
        logic [FIELD_BITS:0]   s;
        logic [FIELD_BITS+1:0] d;
        s = {1'b0, x} + {1'b0, y} + (FIELD_BITS+1)'(cin);
        d = {1'b0, s} - {2'b00, p};
        return d[FIELD_BITS+1] ? s[FIELD_BITS-1:0] : d[FIELD_BITS-1:0];
    endfunction

    // x - y, with p added back on a borrow
    function automatic logic [FIELD_BITS-1:0] mod_sub(logic [FIELD_BITS-1:0] x,
                                                      logic [FIELD_BITS-1:0] y,
                                                      logic [FIELD_BITS-1:0] p);
        logic [FIELD_BITS:0]   d;
        logic [FIELD_BITS-1:0] r;
        d = {1'b0, x} - {1'b0, y};
        r = d[FIELD_BITS-1:0] + p;
        return d[FIELD_BITS] ? r : d[FIELD_BITS-1:0];
    endfunction

endpackage

>>> src/ec_projective_scalar_multiply_unit.sv
// ----------------------------------------------------------------------------
// ec_projective_scalar_multiply_unit - projective montgomery ladder multiplier
// computes k * P on a short weierstrass curve over a 256-bit prime field
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): each request is a command. load
//   commands write one 64-bit limb of the base point X, Y, Z or the scalar.
//   a start request runs the ladder from the top set bit of the scalar down
//   to bit 0 and then returns twelve result requests on the output channel:
//   X limbs 0..3, then Y, then Z, with at_infinity on every word and last
//   on the twelfth.
//   in_stall stays high from a start until the last result is taken.
//   arithmetic: every field multiply runs on the one bit-serial modular
//   adder, which first reduces the multiplicand and then, for each
//   multiplier bit from the top, doubles and adds the reduced multiplicand
//   where that bit is set; a search for the top set bit precedes the ladder.
//   output channel (out_valid / out_stall): a word holds while stalled and
//   the sequencer waits for it; nothing is lost.
//   reset clears the sequencer and loads the standard curve a and prime;
//   base point and scalar must be loaded before the first start.
//   configuration: apb writes of a and p, 64-bit words at 8-byte strides.
// ----------------------------------------------------------------------------
module ec_projective_scalar_multiply_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // command requests
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      cmd,
    input  logic [1:0]                      limb_index,
    input  logic [psmu_pkg::LIMB_BITS-1:0]  limb_data,
    // result requests
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      coord_select,
    output logic [1:0]                      out_limb_index,
    output logic [psmu_pkg::LIMB_BITS-1:0]  out_limb_data,
    output logic                            at_infinity,
    output logic                            last,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psmu_pkg::CFG_AW-1:0]     paddr,
    input  logic [psmu_pkg::LIMB_BITS-1:0]  pwdata,
    output logic [psmu_pkg::LIMB_BITS-1:0]  prdata,
    output logic                            pready
);

    localparam int FB = psmu_pkg::FIELD_BITS;
    localparam int LB = psmu_pkg::LIMB_BITS;

    // configuration registers
    logic [FB-1:0] coef_reg;
    logic [FB-1:0] prime_reg;
    logic [2:0]    cfg_idx;
    logic          cfg_wr;

    // sequencer control
    psmu_pkg::st_t                     state_reg, state_next;
    logic [psmu_pkg::PC_W-1:0]         pc_reg, pc_next;
    logic [psmu_pkg::PC_W-1:0]         ret_reg, ret_next;
    logic [psmu_pkg::CNT_W-1:0]        bit_pos_reg, bit_pos_next;
    logic [psmu_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              red_phase_reg, red_phase_next;
    logic [1:0]                        oc_reg, oc_next;
    logic [1:0]                        ol_reg, ol_next;
    logic                              inf_reg, inf_next;

    // datapath
    logic [FB-1:0] base_reg [3];
    logic [FB-1:0] scalar_reg;
    logic [FB-1:0] acc_reg, acc_next;
    logic [FB-1:0] mulb_reg, mulb_next;
    logic [FB-1:0] src_reg, src_next;
    logic [FB-1:0] opa_reg, opa_next;
    logic [FB-1:0] opb_reg, opb_next;
    logic [FB-1:0] obuf_reg, obuf_next;

    // working store
    logic [FB-1:0]                 slot_mem [psmu_pkg::SLOT_COUNT];
    logic [FB-1:0]                 rd_data_reg;
    logic [psmu_pkg::SLOT_W-1:0]   rd_addr;
    logic                          wr_en;
    logic [FB-1:0]                 wr_data;

    // shared modular adder
    logic [FB-1:0] fx, fy, fsum;
    logic          fcin;

    psmu_pkg::uinstr_t instr;
    logic              in_acc;
    logic              out_acc;

    assign instr   = psmu_pkg::ucode(pc_reg);
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign fsum    = psmu_pkg::fold_add(fx, fy, fcin, prime_reg);

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[psmu_pkg::CFG_AW-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg  <= psmu_pkg::COEF_A_RESET;
            prime_reg <= psmu_pkg::PRIME_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx[2])
            begin
                prime_reg[cfg_idx[1:0]*LB +: LB] <= pwdata;
            end
            else
            begin
                coef_reg[cfg_idx[1:0]*LB +: LB] <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (cfg_idx)
            psmu_pkg::REG_COEF_A0: prdata = coef_reg[0*LB +: LB];
            psmu_pkg::REG_COEF_A1: prdata = coef_reg[1*LB +: LB];
            psmu_pkg::REG_COEF_A2: prdata = coef_reg[2*LB +: LB];
            psmu_pkg::REG_COEF_A3: prdata = coef_reg[3*LB +: LB];
            psmu_pkg::REG_PRIME0:  prdata = prime_reg[0*LB +: LB];
            psmu_pkg::REG_PRIME1:  prdata = prime_reg[1*LB +: LB];
            psmu_pkg::REG_PRIME2:  prdata = prime_reg[2*LB +: LB];
            psmu_pkg::REG_PRIME3:  prdata = prime_reg[3*LB +: LB];
            default:               prdata = '0;
        endcase
    end

    // ---------------- handshake outputs ----------------
    assign in_stall       = (state_reg != psmu_pkg::ST_IDLE);
    assign out_valid      = (state_reg == psmu_pkg::ST_OSEND);
    assign coord_select   = oc_reg;
    assign out_limb_index = ol_reg;
    assign out_limb_data  = obuf_reg[ol_reg*LB +: LB];
    assign at_infinity    = inf_reg;
    assign last           = (oc_reg == psmu_pkg::COORD_Z) && (ol_reg == 2'(psmu_pkg::LIMB_COUNT-1));

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        ret_next       = ret_reg;
        bit_pos_next   = bit_pos_reg;
        cnt_next       = cnt_reg;
        red_phase_next = red_phase_reg;
        oc_next        = oc_reg;
        ol_next        = ol_reg;
        inf_next       = inf_reg;
        acc_next       = acc_reg;
        mulb_next      = mulb_reg;
        src_next       = src_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        obuf_next      = obuf_reg;
        rd_addr        = instr.srca;
        wr_en          = 1'b0;
        wr_data        = fsum;
        fx             = acc_reg;
        fy             = acc_reg;
        fcin           = 1'b0;

        case (state_reg)
            psmu_pkg::ST_IDLE:
            begin
                if (in_acc && (cmd == psmu_pkg::CMD_START))
                begin
                    bit_pos_next = psmu_pkg::CNT_W'(FB-1);
                    state_next   = psmu_pkg::ST_FIND;
                end
            end
            // walk down to the top set bit, bit 0 at the least
            psmu_pkg::ST_FIND:
            begin
                if (!scalar_reg[bit_pos_reg] && (bit_pos_reg != '0))
                begin
                    bit_pos_next = bit_pos_reg - 1'b1;
                end
                else
                begin
                    pc_next    = psmu_pkg::L_START;
                    state_next = psmu_pkg::ST_RDA;
                end
            end
            psmu_pkg::ST_RDA:
            begin
                rd_addr    = instr.srca;
                state_next = psmu_pkg::ST_RDB;
            end
            psmu_pkg::ST_RDB:
            begin
                rd_addr    = instr.srcb;
                opa_next   = rd_data_reg;
                state_next = psmu_pkg::ST_CAP;
            end
            psmu_pkg::ST_CAP:
            begin
                opb_next   = rd_data_reg;
                state_next = psmu_pkg::ST_EXEC;
            end
            psmu_pkg::ST_EXEC:
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = psmu_pkg::ST_RDA;
                case (instr.op)
                    psmu_pkg::OP_MUL, psmu_pkg::OP_MULA:
                    begin
                        pc_next        = pc_reg;
                        src_next       = opb_reg;
                        acc_next       = '0;
                        cnt_next       = psmu_pkg::CNT_W'(FB-1);
                        red_phase_next = 1'b1;
                        state_next     = psmu_pkg::ST_RED;
                    end
                    psmu_pkg::OP_RED:
                    begin
                        pc_next        = pc_reg;
                        case (instr.srca)
                            psmu_pkg::BASE_X: src_next = base_reg[0];
                            psmu_pkg::BASE_Y: src_next = base_reg[1];
                            default:          src_next = base_reg[2];
                        endcase
                        acc_next       = '0;
                        cnt_next       = psmu_pkg::CNT_W'(FB-1);
                        red_phase_next = 1'b0;
                        state_next     = psmu_pkg::ST_RED;
                    end
                    psmu_pkg::OP_ADD:
                    begin
                        fx      = opa_reg;
                        fy      = opb_reg;
                        wr_en   = 1'b1;
                        wr_data = fsum;
                    end
                    psmu_pkg::OP_SUB:
                    begin
                        wr_en   = 1'b1;
                        wr_data = psmu_pkg::mod_sub(opa_reg, opb_reg, prime_reg);
                    end
                    psmu_pkg::OP_MOV:
                    begin
                        wr_en   = 1'b1;
                        wr_data = opa_reg;
                    end
                    psmu_pkg::OP_SETK:
                    begin
                        wr_en   = 1'b1;
                        wr_data = FB'(instr.srca);
                    end
                    psmu_pkg::OP_JZ:
                    begin
                        if (opa_reg == '0)
                        begin
                            pc_next = instr.tgt;
                        end
                    end
                    psmu_pkg::OP_JNZ:
                    begin
                        if (opa_reg != '0)
                        begin
                            pc_next = instr.tgt;
                        end
                    end
                    psmu_pkg::OP_JNE:
                    begin
                        if (opa_reg != opb_reg)
                        begin
                            pc_next = instr.tgt;
                        end
                    end
                    psmu_pkg::OP_JMP:
                    begin
                        pc_next = instr.tgt;
                    end
                    psmu_pkg::OP_JBIT:
                    begin
                        if (scalar_reg[bit_pos_reg])
                        begin
                            pc_next = instr.tgt;
                        end
                    end
                    psmu_pkg::OP_CALL:
                    begin
                        ret_next = pc_reg + 1'b1;
                        pc_next  = instr.tgt;
                    end
                    psmu_pkg::OP_RET:
                    begin
                        pc_next = ret_reg;
                    end
                    psmu_pkg::OP_NEXT:
                    begin
                        if (bit_pos_reg == '0)
                        begin
                            state_next = psmu_pkg::ST_OZRD;
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg - 1'b1;
                            pc_next      = instr.tgt;
                        end
                    end
                    default:
                    begin
                        state_next = psmu_pkg::ST_IDLE;
                    end
                endcase
            end
            // reduction: acc = 2*acc + bit, folded, top bit first
            psmu_pkg::ST_RED:
            begin
                fcin     = src_reg[cnt_reg];
                acc_next = fsum;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (red_phase_reg)
                    begin
                        mulb_next  = fsum;
                        acc_next   = '0;
                        src_next   = (instr.op == psmu_pkg::OP_MULA) ? coef_reg : opa_reg;
                        cnt_next   = psmu_pkg::CNT_W'(FB-1);
                        state_next = psmu_pkg::ST_MDBL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        pc_next    = pc_reg + 1'b1;
                        state_next = psmu_pkg::ST_RDA;
                    end
                end
            end
            // multiply, doubling half
            psmu_pkg::ST_MDBL:
            begin
                acc_next = fsum;
                if (src_reg[cnt_reg])
                begin
                    state_next = psmu_pkg::ST_MADD;
                end
                else if (cnt_reg == '0)
                begin
                    wr_en      = 1'b1;
                    pc_next    = pc_reg + 1'b1;
                    state_next = psmu_pkg::ST_RDA;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            // multiply, adding half
            psmu_pkg::ST_MADD:
            begin
                fy       = mulb_reg;
                acc_next = fsum;
                if (cnt_reg == '0)
                begin
                    wr_en      = 1'b1;
                    pc_next    = pc_reg + 1'b1;
                    state_next = psmu_pkg::ST_RDA;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = psmu_pkg::ST_MDBL;
                end
            end
            psmu_pkg::ST_OZRD:
            begin
                rd_addr    = psmu_pkg::R0Z;
                state_next = psmu_pkg::ST_OZCAP;
            end
            psmu_pkg::ST_OZCAP:
            begin
                inf_next   = (rd_data_reg == '0);
                oc_next    = psmu_pkg::COORD_X;
                state_next = psmu_pkg::ST_ORD;
            end
            psmu_pkg::ST_ORD:
            begin
                rd_addr    = psmu_pkg::R0X + psmu_pkg::SLOT_W'(oc_reg);
                state_next = psmu_pkg::ST_OCAP;
            end
            psmu_pkg::ST_OCAP:
            begin
                obuf_next  = rd_data_reg;
                ol_next    = '0;
                state_next = psmu_pkg::ST_OSEND;
            end
            psmu_pkg::ST_OSEND:
            begin
                if (!out_stall)
                begin
                    if (ol_reg == 2'(psmu_pkg::LIMB_COUNT-1))
                    begin
                        if (oc_reg == psmu_pkg::COORD_Z)
                        begin
                            state_next = psmu_pkg::ST_IDLE;
                        end
                        else
                        begin
                            oc_next    = oc_reg + 1'b1;
                            state_next = psmu_pkg::ST_ORD;
                        end
                    end
                    else
                    begin
                        ol_next = ol_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = psmu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psmu_pkg::ST_IDLE;
            pc_reg        <= '0;
            ret_reg       <= '0;
            bit_pos_reg   <= '0;
            cnt_reg       <= '0;
            red_phase_reg <= 1'b0;
            oc_reg        <= '0;
            ol_reg        <= '0;
            inf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            ret_reg       <= ret_next;
            bit_pos_reg   <= bit_pos_next;
            cnt_reg       <= cnt_next;
            red_phase_reg <= red_phase_next;
            oc_reg        <= oc_next;
            ol_reg        <= ol_next;
            inf_reg       <= inf_next;
        end
    end

    // datapath registers and limb loads
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mulb_reg <= mulb_next;
        src_reg  <= src_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        obuf_reg <= obuf_next;
        if (in_acc)
        begin
            case (cmd)
                psmu_pkg::CMD_LOAD_X: base_reg[0][limb_index*LB +: LB] <= limb_data;
                psmu_pkg::CMD_LOAD_Y: base_reg[1][limb_index*LB +: LB] <= limb_data;
                psmu_pkg::CMD_LOAD_Z: base_reg[2][limb_index*LB +: LB] <= limb_data;
                psmu_pkg::CMD_LOAD_K: scalar_reg[limb_index*LB +: LB]  <= limb_data;
                default:              ;
            endcase
        end
    end

    // working store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[instr.dst] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

endmodule

>>> src/psmu_checker.sv
// ----------------------------------------------------------------------------
// psmu_checker - port-level checks for the scalar multiplier
// watches the command and result channels from the outside
// ----------------------------------------------------------------------------
module psmu_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [2:0]                      cmd,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [1:0]                      coord_select,
    input logic [1:0]                      out_limb_index,
    input logic [psmu_pkg::LIMB_BITS-1:0]  out_limb_data,
    input logic                            last
);

    // a start makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == psmu_pkg::CMD_START) |=> in_stall)
        else $error("start request not followed by busy");

    // results only come while a start is being served
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while idle");

    // the last word is z, top limb
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (coord_select == psmu_pkg::COORD_Z)
                              && (out_limb_index == 2'(psmu_pkg::LIMB_COUNT-1)))
        else $error("last flag on wrong word");

    // a taken word other than the last leaves the block busy
    a_more_words: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> in_stall)
        else $error("block idle before last result");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_limb_data))
        else $error("stalled result changed");

endmodule

bind ec_projective_scalar_multiply_unit psmu_checker u_psmu_checker (.*);

>>> dv/ec_projective_scalar_multiply_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_projective_scalar_multiply_unit_tb - self-checking bench for the ladder
// drives load, start and unused-command requests and predicts every result
// word with a behavioural projective ladder at full 256-bit width. the run
// steps through several curve and prime settings with random idling on both
// channels and one long output hold-off that backs the block up
// ----------------------------------------------------------------------------
module ec_projective_scalar_multiply_unit_tb;

    localparam int FB = psmu_pkg::FIELD_BITS;
    localparam int LB = psmu_pkg::LIMB_BITS;
    localparam int LC = psmu_pkg::LIMB_COUNT;

    typedef logic [FB-1:0] felem_t;

    typedef struct {
        felem_t x;
        felem_t y;
        felem_t z;
    } point_t;

    typedef struct {
        logic [1:0]    coord;
        logic [1:0]    limb;
        logic [LB-1:0] data;
        logic          inf;
        logic          fin;
    } word_t;

    typedef struct {
        logic [2:0]    op;
        logic [1:0]    limb;
        logic [LB-1:0] data;
        bit            inf_known;
    } dir_row_t;

    // command codes the block ignores
    localparam logic [2:0] CMD_NOP5 = 3'd5;
    localparam logic [2:0] CMD_NOP6 = 3'd6;
    localparam logic [2:0] CMD_NOP7 = 3'd7;
    localparam logic [1:0] COORD_Y  = 2'd1;

    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 60000;
    localparam int STALL_LIMIT  = 400000;

    localparam logic [LB-1:0] ONES = {LB{1'b1}};
    localparam logic [LB-1:0] ZERO = '0;
    localparam logic [LB-1:0] ALT5 = {16{4'h5}};
    localparam logic [LB-1:0] ALTA = {16{4'hA}};

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [2:0]                    cmd;
    logic [1:0]                    limb_index;
    logic [LB-1:0]                 limb_data;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    coord_select;
    logic [1:0]                    out_limb_index;
    logic [LB-1:0]                 out_limb_data;
    logic                          at_infinity;
    logic                          last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [psmu_pkg::CFG_AW-1:0]   paddr;
    logic [LB-1:0]                 pwdata;
    logic [LB-1:0]                 prdata;
    logic                          pready;

    // predictor state: curve settings, loaded operands, pending result words
    felem_t        curve_a;
    felem_t        field_p;
    logic [LB-1:0] base_limbs [12];
    logic [LB-1:0] scalar_limbs [4];
    word_t         result_q [$];

    int  idle_pct;
    int  stall_pct;
    bit  small_coords;
    logic hold_go;
    logic hold_out;
    int  mismatches;
    int  words_checked;
    int  starts_sent;
    int  loads_sent;
    int  idle_cycles;

    // directed requests: operand extremes, ignored codes, infinite base,
    // unit scalar and zero scalar
    dir_row_t dir_rows [0:27] = '{
        '{psmu_pkg::CMD_LOAD_X, 2'd0, ONES, 1'b0}, '{psmu_pkg::CMD_LOAD_X, 2'd1, ZERO, 1'b0},
        '{psmu_pkg::CMD_LOAD_X, 2'd2, ALT5, 1'b0}, '{psmu_pkg::CMD_LOAD_X, 2'd3, ALTA, 1'b0},
        '{psmu_pkg::CMD_LOAD_Y, 2'd0, ZERO, 1'b0}, '{psmu_pkg::CMD_LOAD_Y, 2'd1, ONES, 1'b0},
        '{psmu_pkg::CMD_LOAD_Y, 2'd2, ALTA, 1'b0}, '{psmu_pkg::CMD_LOAD_Y, 2'd3, ALT5, 1'b0},
        '{psmu_pkg::CMD_LOAD_Z, 2'd0, ZERO, 1'b0}, '{psmu_pkg::CMD_LOAD_Z, 2'd1, ZERO, 1'b0},
        '{psmu_pkg::CMD_LOAD_Z, 2'd2, ZERO, 1'b0}, '{psmu_pkg::CMD_LOAD_Z, 2'd3, ZERO, 1'b0},
        '{psmu_pkg::CMD_LOAD_K, 2'd0, ONES, 1'b0}, '{psmu_pkg::CMD_LOAD_K, 2'd1, ONES, 1'b0},
        '{psmu_pkg::CMD_LOAD_K, 2'd2, ONES, 1'b0}, '{psmu_pkg::CMD_LOAD_K, 2'd3, ONES, 1'b0},
        '{psmu_pkg::CMD_LOAD_K, 2'd1, ZERO, 1'b0}, '{psmu_pkg::CMD_LOAD_K, 2'd2, ZERO, 1'b0},
        '{psmu_pkg::CMD_LOAD_K, 2'd3, ZERO, 1'b0}, '{psmu_pkg::CMD_LOAD_K, 2'd0, 64'd1, 1'b0},
        // base z of zero: the answer is the point at infinity
        '{psmu_pkg::CMD_START,  2'd3, ONES, 1'b1},
        '{CMD_NOP5,   2'd1, ONES, 1'b0}, '{CMD_NOP6,   2'd2, ZERO, 1'b0},
        '{CMD_NOP7,   2'd3, ALT5, 1'b0},
        '{psmu_pkg::CMD_LOAD_Z, 2'd0, 64'd1, 1'b0}, '{psmu_pkg::CMD_START,  2'd0, ZERO, 1'b0},
        // zero scalar: one step on bit 0 doubles infinity
        '{psmu_pkg::CMD_LOAD_K, 2'd0, ZERO, 1'b0},
        '{psmu_pkg::CMD_START,  2'd0, ZERO, 1'b1}
    };

    ec_projective_scalar_multiply_unit u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .limb_index     (limb_index),
        .limb_data      (limb_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .coord_select   (coord_select),
        .out_limb_index (out_limb_index),
        .out_limb_data  (out_limb_data),
        .at_infinity    (at_infinity),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // field arithmetic, bit for bit as the block folds it
    // ------------------------------------------------------------------------

    // one conditional subtraction of p after a carry or when r reaches p
    function automatic felem_t fold_p(felem_t r, logic carry);
        if (carry || r >= field_p)
            return r - field_p;
        return r;
    endfunction

    function automatic felem_t fadd(felem_t a, felem_t b);
        logic [FB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return fold_p(s[FB-1:0], s[FB]);
    endfunction

    function automatic felem_t fsub(felem_t a, felem_t b);
        logic [FB:0] d;
        d = {1'b0, a} - {1'b0, b};
        return d[FB] ? d[FB-1:0] + field_p : d[FB-1:0];
    endfunction

    // shift in the bits of a from the top, folding after each
    function automatic felem_t freduce(felem_t a);
        felem_t r;
        logic [FB:0] s;
        r = '0;
        for (int i = FB - 1; i >= 0; i--)
        begin
            s = {r, a[i]};
            r = fold_p(s[FB-1:0], s[FB]);
        end
        return r;
    endfunction

    // double and add over the bits of a, multiplicand reduced first
    function automatic felem_t fmul(felem_t a, felem_t b);
        felem_t r;
        felem_t bb;
        logic [FB:0] s;
        bb = freduce(b);
        r  = '0;
        for (int i = FB - 1; i >= 0; i--)
        begin
            s = {r, 1'b0};
            r = fold_p(s[FB-1:0], s[FB]);
            if (a[i])
            begin
                s = {1'b0, r} + {1'b0, bb};
                r = fold_p(s[FB-1:0], s[FB]);
            end
        end
        return r;
    endfunction

    function automatic point_t inf_point();
        point_t q;
        q.x = '0;
        q.y = 1;
        q.z = '0;
        return q;
    endfunction

    function automatic point_t dbl_point(point_t p);
        felem_t w, s, b, h, x2, y2, ss, b4, b8, t;
        point_t d;
        if (p.z == '0 || p.y == '0)
            return inf_point();
        x2  = fmul(p.x, p.x);
        w   = fadd(fmul(curve_a, fmul(p.z, p.z)), fadd(fadd(x2, x2), x2));
        s   = fmul(p.y, p.z);
        b   = fmul(fmul(p.x, p.y), s);
        b4  = fadd(b, b);
        b4  = fadd(b4, b4);
        b8  = fadd(b4, b4);
        h   = fsub(fmul(w, w), b8);
        d.x = fmul(fadd(h, h), s);
        y2  = fmul(p.y, p.y);
        ss  = fmul(s, s);
        t   = fmul(y2, ss);
        t   = fadd(t, t);
        t   = fadd(t, t);
        t   = fadd(t, t);
        d.y = fsub(fmul(w, fsub(b4, h)), t);
        t   = fmul(ss, s);
        t   = fadd(t, t);
        t   = fadd(t, t);
        d.z = fadd(t, t);
        return d;
    endfunction

    function automatic point_t add_points(point_t p, point_t q);
        felem_t u1, u2, v1, v2, u, v, w, vv, vvv, vv2, a;
        point_t s;
        if (p.z == '0)
            return q;
        if (q.z == '0)
            return p;
        u1 = fmul(q.y, p.z);
        u2 = fmul(p.y, q.z);
        v1 = fmul(q.x, p.z);
        v2 = fmul(p.x, q.z);
        // equal x cross products: opposite points or a doubling
        if (v1 == v2)
            return (u1 != u2) ? inf_point() : dbl_point(p);
        u   = fsub(u1, u2);
        v   = fsub(v1, v2);
        w   = fmul(p.z, q.z);
        vv  = fmul(v, v);
        vvv = fmul(vv, v);
        vv2 = fmul(vv, v2);
        a   = fsub(fsub(fmul(fmul(u, u), w), vvv), fadd(vv2, vv2));
        s.x = fmul(v, a);
        s.y = fsub(fmul(u, fsub(vv2, a)), fmul(vvv, u2));
        s.z = fmul(vvv, w);
        return s;
    endfunction

    // full ladder on the loaded base point and scalar, words queued low limb
    // first, x then y then z
    task automatic queue_ladder_result(bit inf_known);
        point_t r0, r1;
        felem_t k, f;
        int top;
        word_t wd;
        r0   = inf_point();
        r1.x = freduce({base_limbs[3], base_limbs[2], base_limbs[1], base_limbs[0]});
        r1.y = freduce({base_limbs[7], base_limbs[6], base_limbs[5], base_limbs[4]});
        r1.z = freduce({base_limbs[11], base_limbs[10], base_limbs[9], base_limbs[8]});
        if (r1.z == '0)
            r1 = inf_point();
        k   = {scalar_limbs[3], scalar_limbs[2], scalar_limbs[1], scalar_limbs[0]};
        top = 0;
        for (int i = FB - 1; i >= 0; i--)
        begin
            if (k[i])
            begin
                top = i;
                break;
            end
        end
        for (int i = top; i >= 0; i--)
        begin
            if (!k[i])
            begin
                r1 = add_points(r0, r1);
                r0 = dbl_point(r0);
            end
            else
            begin
                r0 = add_points(r0, r1);
                r1 = dbl_point(r1);
            end
        end
        // typed-in expectation for rows whose answer is plainly infinity
        if (inf_known)
            r0 = inf_point();
        for (int c = 0; c < 3; c++)
        begin
            f = (c == 0) ? r0.x : ((c == 1) ? r0.y : r0.z);
            for (int i = 0; i < LC; i++)
            begin
                wd.coord = (c == 0) ? psmu_pkg::COORD_X
                                    : ((c == 1) ? COORD_Y : psmu_pkg::COORD_Z);
                wd.limb  = 2'(i);
                wd.data  = f[i*LB +: LB];
                wd.inf   = (r0.z == '0);
                wd.fin   = (c == 2 && i == LC - 1);
                result_q.push_back(wd);
            end
        end
    endtask

    // predictor update for one accepted request
    task automatic apply_request(logic [2:0] op, logic [1:0] li,
                                 logic [LB-1:0] d, bit inf_known);
        case (op)
            psmu_pkg::CMD_LOAD_X, psmu_pkg::CMD_LOAD_Y, psmu_pkg::CMD_LOAD_Z:
            begin
                base_limbs[op * LC + li] = d;
                loads_sent++;
            end
            psmu_pkg::CMD_LOAD_K:
            begin
                scalar_limbs[li] = d;
                loads_sent++;
            end
            psmu_pkg::CMD_START:
            begin
                queue_ladder_result(inf_known);
                starts_sent++;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // request driver: valid stays high across back-to-back requests
    // ------------------------------------------------------------------------
    task automatic send_request(logic [2:0] op, logic [1:0] li,
                                logic [LB-1:0] d, bit inf_known);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        limb_index <= li;
        limb_data  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_request(op, li, d, inf_known);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [LB-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx < psmu_pkg::REG_PRIME0)
            curve_a[idx * LB +: LB] = val;
        else
            field_p[(idx - psmu_pkg::REG_PRIME0) * LB +: LB] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_curve(felem_t a, felem_t p);
        cfg_write(psmu_pkg::REG_COEF_A0, a[63:0]);
        cfg_write(psmu_pkg::REG_COEF_A1, a[127:64]);
        cfg_write(psmu_pkg::REG_COEF_A2, a[191:128]);
        cfg_write(psmu_pkg::REG_COEF_A3, a[255:192]);
        cfg_write(psmu_pkg::REG_PRIME0,  p[63:0]);
        cfg_write(psmu_pkg::REG_PRIME1,  p[127:64]);
        cfg_write(psmu_pkg::REG_PRIME2,  p[191:128]);
        cfg_write(psmu_pkg::REG_PRIME3,  p[255:192]);
    endtask

    // stop offering, let every result come home, then let a trailing load settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random requests: mostly operand loads and starts, some ignored codes
    task automatic random_requests(int count);
        int roll;
        logic [2:0] op;
        logic [1:0] li;
        logic [LB-1:0] d;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            li   = 2'($urandom_range(3));
            d    = {$urandom, $urandom};
            if (roll < 8)
                op = 3'($urandom_range(CMD_NOP5, CMD_NOP7));
            else if (roll < 20)
                op = psmu_pkg::CMD_START;
            else
            begin
                op = 3'($urandom_range(psmu_pkg::CMD_LOAD_X, psmu_pkg::CMD_LOAD_K));
                // scalars stay below 8 so the ladder runs at most three steps
                if (op == psmu_pkg::CMD_LOAD_K)
                    d = (li == 2'd0) ? LB'($urandom_range(7)) : ZERO;
                else if (small_coords)
                    d = (li == 2'd0) ? LB'($urandom_range(9)) : ZERO;
                else if ($urandom_range(9) == 0)
                    // zero limb or the matching limb of p
                    d = $urandom_range(1) ? ZERO : field_p[li * LB +: LB];
            end
            send_request(op, li, d, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver stall and the long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= hold_out || ($urandom_range(99) < stall_pct);

    initial
    begin
        hold_out <= 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        word_t wd;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: coord %0d limb %0d data %h",
                             coord_select, out_limb_index, out_limb_data);
            end
            else
            begin
                wd = result_q.pop_front();
                words_checked++;
                if (coord_select !== wd.coord || out_limb_index !== wd.limb ||
                    out_limb_data !== wd.data || at_infinity !== wd.inf ||
                    last !== wd.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp c%0d l%0d %h inf %b last %b,",
                                  " got c%0d l%0d %h inf %b last %b"},
                                 wd.coord, wd.limb, wd.data, wd.inf, wd.fin,
                                 coord_select, out_limb_index, out_limb_data,
                                 at_infinity, last);
                end
            end
        end
    end

    // watchdog on cycles where no channel moves
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        cmd          <= psmu_pkg::CMD_LOAD_X;
        limb_index   <= 2'd0;
        limb_data    <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        out_stall    <= 1'b0;
        hold_go      <= 1'b0;
        idle_cycles  <= 0;
        idle_pct     = 0;
        stall_pct    = 0;
        small_coords = 0;
        mismatches   = 0;
        words_checked = 0;
        starts_sent  = 0;
        loads_sent   = 0;
        curve_a      = psmu_pkg::COEF_A_RESET;
        field_p      = psmu_pkg::PRIME_RESET;
        foreach (base_limbs[i])
            base_limbs[i] = '0;
        foreach (scalar_limbs[i])
            scalar_limbs[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset curve, no idling: directed rows then random
        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].limb, dir_rows[i].data,
                         dir_rows[i].inf_known);
        random_requests(20);
        drain_results();

        // tiny prime so equal cross products and y = 0 turn up; sender idles
        set_curve(felem_t'(0), felem_t'(7));
        idle_pct     = 73;
        small_coords = 1;
        random_requests(25);
        drain_results();

        // all-ones a and p; receiver stalls and holds off once for a long stretch
        set_curve({FB{1'b1}}, {FB{1'b1}});
        idle_pct     = 0;
        stall_pct    = 73;
        small_coords = 0;
        send_request(psmu_pkg::CMD_START, 2'd0, ZERO, 1'b0);
        hold_go <= 1'b1;
        random_requests(25);
        drain_results();

        // zero prime wraps modulo 2^256; both sides idle lightly
        set_curve(felem_t'(3), felem_t'(0));
        idle_pct  = 9;
        stall_pct = 9;
        random_requests(15);
        drain_results();

        // back to the standard curve
        set_curve(psmu_pkg::COEF_A_RESET, psmu_pkg::PRIME_RESET);
        idle_pct  = 0;
        stall_pct = 0;
        random_requests(15);
        drain_results();

        $display("covered %0d loads and %0d ladder runs over five curve settings",
                 loads_sent, starts_sent);
        $display("%0d result words checked, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && result_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
src/psmu_pkg.sv
src/ec_projective_scalar_multiply_unit.sv
src/psmu_checker.sv
dv/ec_projective_scalar_multiply_unit_tb.sv
